### rtl/core/rfb_pkg.sv
package rfb_pkg;

   localparam int SRC_HEIGHT_DEF = 144;
   localparam int DST_WIDTH_DEF  = 240;
   localparam int DST_HEIGHT_DEF = 400;
   localparam int ROW_STRIDE_DEF = 720;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int OFFSET_W    = 11;
   localparam int COORD_W     = 13;
   localparam int DIM_W       = 10;
   localparam int ADDR_W      = 19;
   localparam int RGB_W       = 24;
   localparam int BYTE_W      = 8;
   localparam int SRC_COORD_W = 8;
   localparam int SHADE_W     = 2;
   localparam int RGB555_W    = 15;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;
   localparam int PIXEL_BYTE_COUNT = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_SHIFT       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_SHIFT       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_WHITE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_LIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_DARK  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_BLACK = 3'd6;

   localparam logic signed [OFFSET_W-1:0] X_SHIFT_RST = 11'sd47;
   localparam logic signed [OFFSET_W-1:0] Y_SHIFT_RST = 11'sd120;
   localparam logic [RGB_W-1:0] PALETTE_WHITE_RST = 24'hFFFFFF;
   localparam logic [RGB_W-1:0] PALETTE_LIGHT_RST = 24'hFF8484;
   localparam logic [RGB_W-1:0] PALETTE_DARK_RST  = 24'h943A3A;
   localparam logic [RGB_W-1:0] PALETTE_BLACK_RST = 24'h000000;

   typedef struct packed {
      logic                       color_mode;
      logic signed [OFFSET_W-1:0] x_shift;
      logic signed [OFFSET_W-1:0] y_shift;
      logic [3:0][RGB_W-1:0]      palette;
   } cfg_type;

endpackage

### rtl/core/rfb_csr.sv
module rfb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rfb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfb_pkg::CSR_DATA_W-1:0]    csr_data,
   output rfb_pkg::cfg_type                  cfg
);

   rfb_pkg::cfg_type cfg_ff;
   rfb_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rfb_pkg::CSR_COLOR_MODE:    cfg_in.color_mode = csr_data[0];
            rfb_pkg::CSR_X_SHIFT:       cfg_in.x_shift = csr_data[rfb_pkg::OFFSET_W-1:0];
            rfb_pkg::CSR_Y_SHIFT:       cfg_in.y_shift = csr_data[rfb_pkg::OFFSET_W-1:0];
            rfb_pkg::CSR_PALETTE_WHITE: cfg_in.palette[0] = csr_data;
            rfb_pkg::CSR_PALETTE_LIGHT: cfg_in.palette[1] = csr_data;
            rfb_pkg::CSR_PALETTE_DARK:  cfg_in.palette[2] = csr_data;
            rfb_pkg::CSR_PALETTE_BLACK: cfg_in.palette[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_mode <= 1'b0;
         cfg_ff.x_shift    <= rfb_pkg::X_SHIFT_RST;
         cfg_ff.y_shift    <= rfb_pkg::Y_SHIFT_RST;
         cfg_ff.palette[0] <= rfb_pkg::PALETTE_WHITE_RST;
         cfg_ff.palette[1] <= rfb_pkg::PALETTE_LIGHT_RST;
         cfg_ff.palette[2] <= rfb_pkg::PALETTE_DARK_RST;
         cfg_ff.palette[3] <= rfb_pkg::PALETTE_BLACK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/rfb_pipe.sv
module rfb_pipe #(
   parameter int SRC_HEIGHT = rfb_pkg::SRC_HEIGHT_DEF,
   parameter int DST_WIDTH  = rfb_pkg::DST_WIDTH_DEF,
   parameter int DST_HEIGHT = rfb_pkg::DST_HEIGHT_DEF,
   parameter int ROW_STRIDE = rfb_pkg::ROW_STRIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rfb_pkg::cfg_type                  cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rfb_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rfb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [0:0]                        rsp_tuser
);

   localparam int CW = rfb_pkg::COORD_W;
   localparam int AW = rfb_pkg::ADDR_W;
   localparam int BW = rfb_pkg::BYTE_W;
   localparam int DW = rfb_pkg::DIM_W;
   localparam logic signed [CW-1:0] FLIP_BASE = CW'(SRC_HEIGHT - 1);
   localparam logic signed [CW-1:0] DX_LIMIT  = CW'(DST_WIDTH);
   localparam logic signed [CW-1:0] DY_LIMIT  = CW'(DST_HEIGHT);
   localparam logic [AW-1:0] STRIDE = AW'(ROW_STRIDE);
   localparam logic [AW-1:0] PIX_BYTES = AW'(rfb_pkg::PIXEL_BYTE_COUNT);

   logic [rfb_pkg::SRC_COORD_W-1:0] in_row;
   logic [rfb_pkg::SRC_COORD_W-1:0] in_col;
   logic [rfb_pkg::SHADE_W-1:0]     in_shade;
   logic [rfb_pkg::RGB555_W-1:0]    in_rgb;
   logic [rfb_pkg::RGB_W-1:0]       pal_word;

   logic s1_ready, s2_ready, s3_ready;

   // stage 1: rotated coordinates, pixel color
   logic                 s1_valid_ff;
   logic signed [CW-1:0] s1_dx_ff, s1_dx_in;
   logic signed [CW-1:0] s1_dy_ff, s1_dy_in;
   logic [BW-1:0]        s1_r_ff, s1_r_in;
   logic [BW-1:0]        s1_g_ff, s1_g_in;
   logic [BW-1:0]        s1_b_ff, s1_b_in;

   // stage 2: clip test, scaled address terms
   logic          s2_valid_ff;
   logic          s2_inside_ff, s2_inside_in;
   logic [AW-1:0] s2_py_ff, s2_py_in;
   logic [AW-1:0] s2_px_ff, s2_px_in;
   logic [BW-1:0] s2_r_ff, s2_g_ff, s2_b_ff;

   // stage 3: output register
   logic          s3_valid_ff;
   logic          s3_we_ff;
   logic [AW-1:0] s3_addr_ff, s3_addr_in;
   logic [BW-1:0] s3_r_ff, s3_r_in;
   logic [BW-1:0] s3_g_ff, s3_g_in;
   logic [BW-1:0] s3_b_ff, s3_b_in;

   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   assign in_row   = req_tdata[7:0];
   assign in_col   = req_tdata[15:8];
   assign in_shade = req_tdata[17:16];
   assign in_rgb   = req_tdata[32:18];
   assign pal_word = cfg.palette[in_shade];

   always_comb begin
      s1_dx_in = FLIP_BASE - CW'(in_row) + CW'(cfg.x_shift);
      s1_dy_in = CW'(in_col) + CW'(cfg.y_shift);
      if (cfg.color_mode) begin
         s1_r_in = {in_rgb[4:0], 3'b000};
         s1_g_in = {in_rgb[9:5], 3'b000};
         s1_b_in = {in_rgb[14:10], 3'b000};
      end else begin
         s1_r_in = pal_word[23:16];
         s1_g_in = pal_word[15:8];
         s1_b_in = pal_word[7:0];
      end
   end

   always_comb begin
      s2_inside_in = !s1_dx_ff[CW-1] && (s1_dx_ff < DX_LIMIT)
                     && !s1_dy_ff[CW-1] && (s1_dy_ff < DY_LIMIT);
      s2_py_in = AW'(s1_dy_ff[DW-1:0]) * STRIDE;
      s2_px_in = AW'(s1_dx_ff[DW-1:0]) * PIX_BYTES;
   end

   always_comb begin
      if (s2_inside_ff) begin
         s3_addr_in = s2_py_ff + s2_px_ff;
         s3_r_in    = s2_r_ff;
         s3_g_in    = s2_g_ff;
         s3_b_in    = s2_b_ff;
      end else begin
         s3_addr_in = '0;
         s3_r_in    = '0;
         s3_g_in    = '0;
         s3_b_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_tvalid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
         s1_r_ff  <= s1_r_in;
         s1_g_ff  <= s1_g_in;
         s1_b_ff  <= s1_b_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_inside_ff <= s2_inside_in;
         s2_py_ff     <= s2_py_in;
         s2_px_ff     <= s2_px_in;
         s2_r_ff      <= s1_r_ff;
         s2_g_ff      <= s1_g_ff;
         s2_b_ff      <= s1_b_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_we_ff   <= s2_inside_ff;
         s3_addr_ff <= s3_addr_in;
         s3_r_ff    <= s3_r_in;
         s3_g_ff    <= s3_g_in;
         s3_b_ff    <= s3_b_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tuser  = s3_we_ff;
   assign rsp_tdata  = {5'b00000, s3_r_ff, s3_g_ff, s3_b_ff, s3_addr_ff};

   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s3_we_ff |->
         s3_addr_ff == '0 && s3_r_ff == '0 && s3_g_ff == '0 && s3_b_ff == '0)
      else $error("clipped item carries nonzero payload");

   a_inside_nonneg: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_dx_ff[CW-1] || s1_dy_ff[CW-1]) |-> !s2_inside_in)
      else $error("inside flag set for negative destination");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_dx_ff) && $stable(s1_dy_ff))
      else $error("stage 1 item lost under stall");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("empty pipeline refuses input");

endmodule

### rtl/core/rotated_framebuffer_pixel_blit.sv
// Accepts one item per cycle while the output is not stalled; three register
// stages (rotate and color, clip and constant multiply, address add), each with
// its own valid bit, lie between request and response, the last driving it.
// A stalled output holds every full stage; empty stages ahead of it keep filling.
// Reset (synchronous, active high) clears all valid bits and loads the
// default offsets, mono mode and default palette.
module rotated_framebuffer_pixel_blit #(
   parameter int SRC_HEIGHT = rfb_pkg::SRC_HEIGHT_DEF,
   parameter int DST_WIDTH  = rfb_pkg::DST_WIDTH_DEF,
   parameter int DST_HEIGHT = rfb_pkg::DST_HEIGHT_DEF,
   parameter int ROW_STRIDE = rfb_pkg::ROW_STRIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // src_row, src_col, shade, rgb555, zero pad
   input  logic [rfb_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // byte_address, blue, green, red, zero pad
   output logic [rfb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // write_enable
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rfb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfb_pkg::CSR_DATA_W-1:0]    csr_data
);

   rfb_pkg::cfg_type cfg;

   rfb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rfb_pipe #(
      .SRC_HEIGHT (SRC_HEIGHT),
      .DST_WIDTH  (DST_WIDTH),
      .DST_HEIGHT (DST_HEIGHT),
      .ROW_STRIDE (ROW_STRIDE)
   ) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sim/rotated_framebuffer_pixel_blit_test.sv
`timescale 1ns / 100ps

module rotated_framebuffer_pixel_blit_test;

   localparam logic [rfb_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int NUM_CSR_SLOTS = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PIXELS_PER_PHASE = 160;
   localparam int DRAIN_AT_ITEM = 700;
   localparam int STALL_LIMIT = 1000;
   localparam int END_WAIT = 8;

   typedef struct packed {
      logic [rfb_pkg::RGB555_W-1:0]    rgb555;
      logic [rfb_pkg::SHADE_W-1:0]     shade;
      logic [rfb_pkg::SRC_COORD_W-1:0] src_col;
      logic [rfb_pkg::SRC_COORD_W-1:0] src_row;
   } pixel_item_type;

   typedef struct packed {
      logic                       write_enable;
      logic [rfb_pkg::ADDR_W-1:0] byte_address;
      logic [rfb_pkg::BYTE_W-1:0] blue;
      logic [rfb_pkg::BYTE_W-1:0] green;
      logic [rfb_pkg::BYTE_W-1:0] red;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rfb_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rfb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rfb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rfb_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the register file
   logic                                mode_q;
   logic signed [rfb_pkg::OFFSET_W-1:0] x_shift_q;
   logic signed [rfb_pkg::OFFSET_W-1:0] y_shift_q;
   logic [rfb_pkg::RGB_W-1:0]           palette_q [4];

   logic [rfb_pkg::CSR_DATA_W-1:0] next_regs [NUM_CSR_SLOTS];

   pixel_item_type   pending_pixels [$];
   pixel_result_type expected_writes [$];

   int send_idle_pct = 33;
   int recv_idle_pct = 73;
   int errors = 0;
   int accepted_items = 0;
   int checked_items = 0;
   int written_pixels = 0;
   int clipped_pixels = 0;
   int settings_used = 1;
   bit drain_hold = 1'b0;

   rotated_framebuffer_pixel_blit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic pixel_result_type place_pixel(pixel_item_type p);
      pixel_result_type r;
      int dst_x;
      int dst_y;
      int addr;
      logic [rfb_pkg::RGB_W-1:0] word;
      r = '0;
      dst_x = rfb_pkg::SRC_HEIGHT_DEF - 1 - int'(p.src_row) + int'(x_shift_q);
      dst_y = int'(p.src_col) + int'(y_shift_q);
      if (dst_x >= 0 && dst_x < rfb_pkg::DST_WIDTH_DEF &&
          dst_y >= 0 && dst_y < rfb_pkg::DST_HEIGHT_DEF) begin
         addr = dst_y * rfb_pkg::ROW_STRIDE_DEF + dst_x * rfb_pkg::PIXEL_BYTE_COUNT;
         r.write_enable = 1'b1;
         r.byte_address = addr[rfb_pkg::ADDR_W-1:0];
         if (mode_q) begin
            r.red   = {p.rgb555[4:0], 3'b000};
            r.green = {p.rgb555[9:5], 3'b000};
            r.blue  = {p.rgb555[14:10], 3'b000};
         end else begin
            word    = palette_q[p.shade];
            r.red   = word[23:16];
            r.green = word[15:8];
            r.blue  = word[7:0];
         end
      end
      return r;
   endfunction

   function automatic pixel_item_type mk_pixel(int row, int col, int shade, int rgb);
      pixel_item_type p;
      p.src_row = row[rfb_pkg::SRC_COORD_W-1:0];
      p.src_col = col[rfb_pkg::SRC_COORD_W-1:0];
      p.shade   = shade[rfb_pkg::SHADE_W-1:0];
      p.rgb555  = rgb[rfb_pkg::RGB555_W-1:0];
      return p;
   endfunction

   function automatic pixel_item_type random_pixel();
      int row;
      int col;
      row = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(143);
      col = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(159);
      return mk_pixel(row, col, $urandom_range(3), $urandom_range(32767));
   endfunction

   function automatic logic [rfb_pkg::CSR_DATA_W-1:0] offset_word(int value);
      logic [rfb_pkg::CSR_DATA_W-1:0] w;
      w = $urandom;
      w[rfb_pkg::OFFSET_W-1:0] = value[rfb_pkg::OFFSET_W-1:0];
      return w;
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic apply_csr(input logic [rfb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rfb_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         rfb_pkg::CSR_COLOR_MODE:    mode_q = val[0];
         rfb_pkg::CSR_X_SHIFT:       x_shift_q = val[rfb_pkg::OFFSET_W-1:0];
         rfb_pkg::CSR_Y_SHIFT:       y_shift_q = val[rfb_pkg::OFFSET_W-1:0];
         rfb_pkg::CSR_PALETTE_WHITE: palette_q[0] = val;
         rfb_pkg::CSR_PALETTE_LIGHT: palette_q[1] = val;
         rfb_pkg::CSR_PALETTE_DARK:  palette_q[2] = val;
         rfb_pkg::CSR_PALETTE_BLACK: palette_q[3] = val;
         default: ;
      endcase
   endtask

   // writes every slot of next_regs, the unused index included
   task automatic write_config();
      for (int i = 0; i < NUM_CSR_SLOTS; i++) begin
         csr_valid <= 1'b1;
         csr_index <= rfb_pkg::CSR_INDEX_W'(i);
         csr_data  <= next_regs[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         apply_csr(rfb_pkg::CSR_INDEX_W'(i), next_regs[i]);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_tvalid || expected_writes.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_writes.push_back(place_pixel(pending_pixels.pop_front()));
            accepted_items++;
            if (accepted_items == DRAIN_AT_ITEM) drain_hold = 1'b1;
         end
         if (drain_hold && expected_writes.size() == 0) drain_hold = 1'b0;
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() != 0 && !drain_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {7'b0, pending_pixels[0]};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_result_type got;
      pixel_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.write_enable = rsp_tuser[0];
            got.byte_address = rsp_tdata[18:0];
            got.blue         = rsp_tdata[26:19];
            got.green        = rsp_tdata[34:27];
            got.red          = rsp_tdata[42:35];
            if (expected_writes.size() == 0) begin
               flag_error($sformatf("result with no item outstanding: %h", got));
            end else begin
               want = expected_writes.pop_front();
               if (got.write_enable != want.write_enable)
                  flag_error($sformatf("item %0d write_enable %0d, want %0d",
                                       checked_items, got.write_enable, want.write_enable));
               if (got.byte_address != want.byte_address)
                  flag_error($sformatf("item %0d byte_address %0d, want %0d",
                                       checked_items, got.byte_address, want.byte_address));
               if (got.blue != want.blue)
                  flag_error($sformatf("item %0d blue %h, want %h",
                                       checked_items, got.blue, want.blue));
               if (got.green != want.green)
                  flag_error($sformatf("item %0d green %h, want %h",
                                       checked_items, got.green, want.green));
               if (got.red != want.red)
                  flag_error($sformatf("item %0d red %h, want %h",
                                       checked_items, got.red, want.red));
               if (want.write_enable) written_pixels++;
               else clipped_pixels++;
            end
            checked_items++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      mode_q       = 1'b0;
      x_shift_q    = rfb_pkg::X_SHIFT_RST;
      y_shift_q    = rfb_pkg::Y_SHIFT_RST;
      palette_q[0] = rfb_pkg::PALETTE_WHITE_RST;
      palette_q[1] = rfb_pkg::PALETTE_LIGHT_RST;
      palette_q[2] = rfb_pkg::PALETTE_DARK_RST;
      palette_q[3] = rfb_pkg::PALETTE_BLACK_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: mono, row flip edges, rows past the screen
      pending_pixels.push_back(mk_pixel(0, 0, 0, 0));
      pending_pixels.push_back(mk_pixel(143, 159, 1, 'h7FFF));
      pending_pixels.push_back(mk_pixel(190, 0, 2, 0));
      pending_pixels.push_back(mk_pixel(191, 5, 3, 'h7FFF));
      pending_pixels.push_back(mk_pixel(144, 160, 0, 'h1234));
      pending_pixels.push_back(mk_pixel(255, 255, 1, 'h7FFF));
      pending_pixels.push_back(mk_pixel(0, 255, 3, 0));
      for (int s = 0; s < 4; s++) pending_pixels.push_back(mk_pixel(100, 80, s, 'h5555));
      wait_drained();

      // color mode, destination placed at the far display edges
      next_regs[rfb_pkg::CSR_COLOR_MODE]    = 24'h000001;
      next_regs[rfb_pkg::CSR_X_SHIFT]       = offset_word(96);
      next_regs[rfb_pkg::CSR_Y_SHIFT]       = offset_word(240);
      next_regs[rfb_pkg::CSR_PALETTE_WHITE] = $urandom;
      next_regs[rfb_pkg::CSR_PALETTE_LIGHT] = $urandom;
      next_regs[rfb_pkg::CSR_PALETTE_DARK]  = $urandom;
      next_regs[rfb_pkg::CSR_PALETTE_BLACK] = $urandom;
      next_regs[CSR_UNUSED]                 = $urandom;
      write_config();
      pending_pixels.push_back(mk_pixel(0, 159, 0, 'h7FFF));
      pending_pixels.push_back(mk_pixel(0, 160, 1, 'h7FFF));
      pending_pixels.push_back(mk_pixel(143, 0, 2, 0));
      pending_pixels.push_back(mk_pixel(0, 0, 3, 'h001F));
      pending_pixels.push_back(mk_pixel(10, 10, 0, 'h03E0));
      pending_pixels.push_back(mk_pixel(20, 20, 1, 'h7C00));
      pending_pixels.push_back(mk_pixel(200, 100, 2, 'h2AAA));
      pending_pixels.push_back(mk_pixel(240, 0, 3, 'h7FFF));
      pending_pixels.push_back(mk_pixel(239, 0, 0, 'h7FFF));
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 33;
            recv_idle_pct = 73;
         end else if (ph < 6) begin
            send_idle_pct = 73;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         next_regs[rfb_pkg::CSR_COLOR_MODE] = $urandom;
         next_regs[CSR_UNUSED]              = $urandom;
         if (ph == 0) begin
            next_regs[rfb_pkg::CSR_X_SHIFT] = offset_word(-1024);
            next_regs[rfb_pkg::CSR_Y_SHIFT] = offset_word(1023);
            for (int k = rfb_pkg::CSR_PALETTE_WHITE; k <= rfb_pkg::CSR_PALETTE_BLACK; k++)
               next_regs[k] = '0;
         end else if (ph == 1) begin
            next_regs[rfb_pkg::CSR_X_SHIFT] = offset_word(1023);
            next_regs[rfb_pkg::CSR_Y_SHIFT] = offset_word(-1024);
            for (int k = rfb_pkg::CSR_PALETTE_WHITE; k <= rfb_pkg::CSR_PALETTE_BLACK; k++)
               next_regs[k] = 24'hFFFFFF;
         end else begin
            next_regs[rfb_pkg::CSR_X_SHIFT] = offset_word($urandom_range(420) - 160);
            next_regs[rfb_pkg::CSR_Y_SHIFT] = offset_word($urandom_range(580) - 170);
            for (int k = rfb_pkg::CSR_PALETTE_WHITE; k <= rfb_pkg::CSR_PALETTE_BLACK; k++)
               next_regs[k] = $urandom;
         end
         write_config();
         for (int n = 0; n < PIXELS_PER_PHASE; n++) pending_pixels.push_back(random_pixel());
         wait_drained();
      end

      repeat (END_WAIT) @(posedge clock);
      $display("Checked %0d pixels under %0d register settings: %0d written, %0d clipped.",
               checked_items, settings_used, written_pixels, clipped_pixels);
      $display("Mono and color modes, offset extremes and off-screen source rows were used.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
